>>> rtl/first_fit_heap_allocator_assert.svh
// Assertion macros used by the checker file.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define FFHA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define FFHA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Implication that also holds during reset.
`define FFHA_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> rtl/ffha_pkg.sv
`timescale 1ns / 1ps
package ffha_pkg;

   localparam int unsigned OFFSET_W = 20;
   localparam int unsigned STATUS_W = 3;

   typedef enum logic [1:0] {
      FUNC_INIT  = 2'd0,
      FUNC_RESET = 2'd1,
      FUNC_ALLOC = 2'd2,
      FUNC_FREE  = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_NOT_INIT = 3'd1,
      ST_ZERO     = 3'd2,
      ST_NO_FIT   = 3'd3,
      ST_DOUBLE   = 3'd4,
      ST_UNKNOWN  = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_A_CHECK,
      S_SCAN,
      S_SPLIT1,
      S_SPLIT2,
      S_SPLIT3,
      S_F_CHECK,
      S_F_PREV,
      S_F_NEXT,
      S_F_WRITE,
      S_F_FIX,
      S_FINISH
   } state_type;

endpackage

>>> rtl/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  func, request_bytes, payload_offset
// rsp_      out        rsp_valid/rsp_ready  status, granted_offset
//
// One item at a time; the block table is a one-port-read, one-port-write memory.
// Init/reset/rejected items go straight to S_FINISH. Allocate walks the list and,
// if a split is needed, scans up to MAX_BLOCKS entries for a spare one to split into.
// Free walks, then merges free neighbors. The walk is one memory read per cycle.
// Synchronous reset clears the FSM, entry valid bits, heap-ready flag and rsp_valid.
// A waiting result sits in the output register; a new item is taken meanwhile.
module first_fit_heap_allocator #(
   parameter int unsigned HEAP_BYTES   = 1048576,
   parameter int unsigned HEADER_BYTES = 32,
   parameter int unsigned MAX_BLOCKS   = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_func,
   input  logic [ffha_pkg::OFFSET_W-1:0]       req_request_bytes,
   input  logic [ffha_pkg::OFFSET_W-1:0]       req_payload_offset,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ffha_pkg::STATUS_W-1:0]       rsp_status,
   output logic [ffha_pkg::OFFSET_W-1:0]       rsp_granted_offset
);
   import ffha_pkg::*;

   localparam int unsigned HB = $clog2(HEAP_BYTES) + 1;
   localparam int unsigned BW = (HB > 22) ? HB : 22;
   localparam int unsigned LW = $clog2(MAX_BLOCKS + 1);
   localparam int unsigned IW = $clog2(MAX_BLOCKS);
   localparam logic [LW-1:0] LINK_NONE = LW'(MAX_BLOCKS);
   localparam logic [BW-1:0] HDR = BW'(HEADER_BYTES);
   localparam logic [BW-1:0] INIT_BYTES = BW'(HEAP_BYTES - HEADER_BYTES);
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_BLOCKS - 1);

   typedef struct packed {
      logic [BW-1:0] start;
      logic [BW-1:0] bytes;
      logic          is_free;
      logic [LW-1:0] next;
      logic [LW-1:0] prev;
   } entry_type;

   // block table memory
   entry_type block_mem_ff [MAX_BLOCKS];
   entry_type rd_data_ff;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data;

   state_type state_ff, state_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [IW-1:0] work_ff, work_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] nb_ff, nb_in;
   logic [BW-1:0] size_ff, size_in;
   logic [OFFSET_W-1:0] off_ff, off_in;
   entry_type ent_ff, ent_in;
   logic merged_ff, merged_in;
   logic [MAX_BLOCKS-1:0] valid_ff, valid_in;
   logic ready_ff, ready_in;
   status_type res_status_ff, res_status_in;
   logic [OFFSET_W-1:0] res_granted_ff, res_granted_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [OFFSET_W-1:0] rsp_granted_ff, rsp_granted_in;

   entry_type e;
   logic fits, split_need, e_next_ok, e_prev_ok, w_next_ok, found, slot_free;
   logic [BW-1:0] e_payload, w_payload;
   logic [OFFSET_W:0] size_rnd;
   entry_type build_ent;

   // decode current read data
   assign e          = rd_data_ff;
   assign e_payload  = e.start + HDR;
   assign w_payload  = ent_ff.start + HDR;
   assign fits       = e.is_free && (e.bytes >= size_ff);
   assign split_need = e.bytes > (size_ff + HDR + BW'(8));
   assign e_next_ok  = e.next < LINK_NONE;
   assign e_prev_ok  = e.prev < LINK_NONE;
   assign w_next_ok  = ent_ff.next < LINK_NONE;
   assign found      = e_payload[OFFSET_W-1:0] == off_ff;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign size_rnd   = ({1'b0, req_request_bytes} + (OFFSET_W+1)'(7))
                       & ~(OFFSET_W+1)'(7);
   assign build_ent  = '{start: '0, bytes: INIT_BYTES, is_free: 1'b1,
                         next: LINK_NONE, prev: LINK_NONE};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (func_type'(req_func))
                  FUNC_ALLOC: state_in = (!ready_ff || req_request_bytes == '0)
                                         ? S_FINISH : S_A_CHECK;
                  FUNC_FREE:  state_in = (!ready_ff || req_payload_offset == '0)
                                         ? S_FINISH : S_F_CHECK;
                  default:    state_in = S_FINISH;
               endcase
            end
         end
         S_A_CHECK: begin
            if (fits) state_in = split_need ? S_SCAN : S_FINISH;
            else state_in = e_next_ok ? S_A_CHECK : S_FINISH;
         end
         S_SCAN: begin
            if (!valid_ff[idx_ff]) state_in = S_SPLIT1;
            else if (idx_ff == LAST_IDX) state_in = S_FINISH;
         end
         S_SPLIT1: state_in = w_next_ok ? S_SPLIT2 : S_SPLIT3;
         S_SPLIT2: state_in = S_SPLIT3;
         S_SPLIT3: state_in = S_FINISH;
         S_F_CHECK: begin
            if (found) begin
               if (e.is_free) state_in = S_FINISH;
               else if (e_prev_ok) state_in = S_F_PREV;
               else state_in = e_next_ok ? S_F_NEXT : S_F_WRITE;
            end else begin
               state_in = e_next_ok ? S_F_CHECK : S_FINISH;
            end
         end
         S_F_PREV:  state_in = w_next_ok ? S_F_NEXT : S_F_WRITE;
         S_F_NEXT:  state_in = S_F_WRITE;
         S_F_WRITE: state_in = (w_next_ok && merged_ff) ? S_F_FIX : S_FINISH;
         S_F_FIX:   state_in = S_FINISH;
         S_FINISH:  state_in = slot_free ? S_IDLE : S_FINISH;
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cur_in         = cur_ff;
      work_in        = work_ff;
      idx_in         = idx_ff;
      nb_in          = nb_ff;
      size_in        = size_ff;
      off_in         = off_ff;
      ent_in         = ent_ff;
      merged_in      = merged_ff;
      valid_in       = valid_ff;
      ready_in       = ready_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rd_addr        = cur_ff;
      wr_en          = 1'b0;
      wr_addr        = cur_ff;
      wr_data        = ent_ff;
      req_ready      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = '0;
            if (req_valid) begin
               cur_in         = '0;
               off_in         = req_payload_offset;
               size_in        = BW'(size_rnd);
               res_status_in  = ST_OK;
               res_granted_in = '0;
               case (func_type'(req_func))
                  FUNC_INIT, FUNC_RESET: begin
                     if (func_type'(req_func) == FUNC_RESET || !ready_ff) begin
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        wr_data  = build_ent;
                        valid_in = MAX_BLOCKS'(1);
                        ready_in = 1'b1;
                     end
                  end
                  FUNC_ALLOC: begin
                     if (!ready_ff) res_status_in = ST_NOT_INIT;
                     else if (req_request_bytes == '0) res_status_in = ST_ZERO;
                  end
                  default: begin
                     if (!ready_ff) res_status_in = ST_NOT_INIT;
                  end
               endcase
            end
         end
         S_A_CHECK: begin
            if (fits) begin
               ent_in = e;
               idx_in = '0;
               if (!split_need) begin
                  wr_en          = 1'b1;
                  wr_data        = e;
                  wr_data.is_free = 1'b0;
                  res_granted_in = e_payload[OFFSET_W-1:0];
               end
            end else if (e_next_ok) begin
               cur_in  = e.next[IW-1:0];
               rd_addr = e.next[IW-1:0];
            end else begin
               res_status_in = ST_NO_FIT;
            end
         end
         S_SCAN: begin
            if (!valid_ff[idx_ff]) begin
               nb_in = idx_ff;
            end else if (idx_ff == LAST_IDX) begin
               // table full: grant the block whole
               wr_en           = 1'b1;
               wr_data         = ent_ff;
               wr_data.is_free = 1'b0;
               res_granted_in  = w_payload[OFFSET_W-1:0];
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_SPLIT1: begin
            wr_en           = 1'b1;
            wr_addr         = nb_ff;
            wr_data.start   = ent_ff.start + HDR + size_ff;
            wr_data.bytes   = ent_ff.bytes - size_ff - HDR;
            wr_data.is_free = 1'b1;
            wr_data.next    = ent_ff.next;
            wr_data.prev    = LW'(cur_ff);
            valid_in[nb_ff] = 1'b1;
            rd_addr         = ent_ff.next[IW-1:0];
         end
         S_SPLIT2: begin
            wr_en        = 1'b1;
            wr_addr      = ent_ff.next[IW-1:0];
            wr_data      = e;
            wr_data.prev = LW'(nb_ff);
         end
         S_SPLIT3: begin
            wr_en           = 1'b1;
            wr_data         = ent_ff;
            wr_data.bytes   = size_ff;
            wr_data.is_free = 1'b0;
            wr_data.next    = LW'(nb_ff);
            res_granted_in  = w_payload[OFFSET_W-1:0];
         end
         S_F_CHECK: begin
            if (found) begin
               if (e.is_free) begin
                  res_status_in = ST_DOUBLE;
               end else begin
                  ent_in         = e;
                  ent_in.is_free = 1'b1;
                  work_in        = cur_ff;
                  merged_in      = 1'b0;
                  rd_addr        = e_prev_ok ? e.prev[IW-1:0] : e.next[IW-1:0];
               end
            end else if (e_next_ok) begin
               cur_in  = e.next[IW-1:0];
               rd_addr = e.next[IW-1:0];
            end else begin
               res_status_in = ST_UNKNOWN;
            end
         end
         S_F_PREV: begin
            // merge into a free predecessor
            if (e.is_free) begin
               ent_in.start     = e.start;
               ent_in.bytes     = e.bytes + HDR + ent_ff.bytes;
               ent_in.prev      = e.prev;
               work_in          = ent_ff.prev[IW-1:0];
               valid_in[work_ff] = 1'b0;
               merged_in        = 1'b1;
            end
            rd_addr = ent_ff.next[IW-1:0];
         end
         S_F_NEXT: begin
            // absorb a free successor
            if (e.is_free) begin
               ent_in.bytes = ent_ff.bytes + HDR + e.bytes;
               ent_in.next  = e.next;
               valid_in[ent_ff.next[IW-1:0]] = 1'b0;
               merged_in    = 1'b1;
            end
         end
         S_F_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = work_ff;
            wr_data = ent_ff;
            rd_addr = ent_ff.next[IW-1:0];
         end
         S_F_FIX: begin
            wr_en        = 1'b1;
            wr_addr      = ent_ff.next[IW-1:0];
            wr_data      = e;
            wr_data.prev = LW'(work_ff);
         end
         S_FINISH: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_granted_in = res_granted_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // table memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) block_mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= block_mem_ff[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      work_ff        <= work_in;
      idx_ff         <= idx_in;
      nb_ff          <= nb_in;
      size_ff        <= size_in;
      off_ff         <= off_in;
      ent_ff         <= ent_in;
      merged_ff      <= merged_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_offset = rsp_granted_ff;

endmodule

>>> rtl/ffha_checker.sv
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_assert.svh"
module ffha_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [1:0]                    req_func,
   input logic [ffha_pkg::OFFSET_W-1:0] req_request_bytes,
   input logic [ffha_pkg::OFFSET_W-1:0] req_payload_offset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ffha_pkg::STATUS_W-1:0] rsp_status,
   input logic [ffha_pkg::OFFSET_W-1:0] rsp_granted_offset
);
   import ffha_pkg::*;

   // hold a stalled result
   `FFHA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_granted_offset), "rsp item changed while stalled")
   // only a good allocate carries an offset
   `FFHA_ASSERT_NOW(a_grant_zero, rsp_valid && rsp_status != ST_OK, rsp_granted_offset == '0, "offset on failed item")
   // one item in flight
   `FFHA_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready, "second item taken while busy")
   // drop output after reset
   `FFHA_ASSERT_ALWAYS(a_reset_quiet, $past(reset), !rsp_valid, "rsp_valid after reset")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);
